>>> hw/rtl/lwpw_pkg.sv
// Package for the window pixel writer: word types of both channels, command codes,
// display bus opcodes and the byte positions of a drawing sequence.
// Depends on nothing; used by lcd_window_pixel_writer.
`default_nettype none

package lwpw_pkg;

  localparam int CNT_W  = 17;
  localparam int HASH_W = 32;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    CMD_WINDOW = 2'd0,
    CMD_PIXEL  = 2'd1,
    CMD_PLOT   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  localparam logic [7:0] OP_COL_SET   = 8'h2A;
  localparam logic [7:0] OP_ROW_SET   = 8'h2B;
  localparam logic [7:0] OP_MEM_WRITE = 8'h2C;

  localparam logic [3:0] BYTE_COL_CMD    = 4'd0;
  localparam logic [3:0] BYTE_COL_LO_HI  = 4'd1;
  localparam logic [3:0] BYTE_COL_LO_LO  = 4'd2;
  localparam logic [3:0] BYTE_COL_HI_HI  = 4'd3;
  localparam logic [3:0] BYTE_COL_HI_LO  = 4'd4;
  localparam logic [3:0] BYTE_ROW_CMD    = 4'd5;
  localparam logic [3:0] BYTE_ROW_LO_HI  = 4'd6;
  localparam logic [3:0] BYTE_ROW_LO_LO  = 4'd7;
  localparam logic [3:0] BYTE_ROW_HI_HI  = 4'd8;
  localparam logic [3:0] BYTE_ROW_HI_LO  = 4'd9;
  localparam logic [3:0] BYTE_MEM_WRITE  = 4'd10;
  localparam logic [3:0] BYTE_PIX_HI     = 4'd11;
  localparam logic [3:0] BYTE_PIX_LO     = 4'd12;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] x_first;
    logic [15:0] y_first;
    logic [15:0] x_second;
    logic [15:0] y_second;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } in_word_t;

  typedef struct packed {
    logic [7:0]        bus_byte;
    logic              is_data;
    logic              last;
    logic [CNT_W-1:0]  pixels_left;
    logic [HASH_W-1:0] image_hash;
  } out_word_t;

  typedef struct packed {
    logic [15:0]       c_lo;
    logic [15:0]       c_hi;
    logic [15:0]       r_lo;
    logic [15:0]       r_hi;
    logic [7:0]        pix_hi;
    logic [7:0]        pix_lo;
    logic [3:0]        end_idx;
    logic [CNT_W-1:0]  pixels_left;
    logic [HASH_W-1:0] hash;
  } job_t;

endpackage

`default_nettype wire

>>> hw/rtl/lcd_window_pixel_writer.sv
// Window pixel writer: turns drawing requests into the command and data byte stream
// of a TFT controller on an 8-bit parallel bus. Depends on lwpw_pkg.
//
//   Port group  Direction  Handshake            Word
//   in_         in         in_valid/in_stall    in_word  (lwpw_pkg::in_word_t)
//   out_        out        out_valid/out_stall  out_word (lwpw_pkg::out_word_t)
//   cfg_        in         cfg_we               cfg_wdata (hash enable)
//
// A request passes an input register, a clipping stage and a counting stage, then a
// byte sequencer that sends one bus byte per cycle while out_stall is low, through the
// output register. A streamed pixel sends two bytes, an open window eleven and a plot
// thirteen. The first byte of a request reaches the output register after passing the
// input, clipping and job registers in that order.
// Requests that send nothing are dropped at the counting stage. Reset is synchronous and
// clears the hash and the pixel count; a stall holds every stage that cannot move on.
`default_nettype none

module lcd_window_pixel_writer #(
  parameter int DISPLAY_WIDTH  = 240,
  parameter int DISPLAY_HEIGHT = 320
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic                cfg_wdata,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire lwpw_pkg::in_word_t  in_word,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output lwpw_pkg::out_word_t      out_word
);

  import lwpw_pkg::*;

  localparam int MaxDim = (DISPLAY_WIDTH > DISPLAY_HEIGHT) ? DISPLAY_WIDTH : DISPLAY_HEIGHT;
  localparam int DimW   = $clog2(MaxDim + 1);
  localparam int ProdW  = 2 * DimW;
  localparam int ExtW   = (ProdW > CNT_W) ? ProdW : CNT_W;

  localparam logic [15:0] ColLast = 16'(DISPLAY_WIDTH - 1);
  localparam logic [15:0] RowLast = 16'(DISPLAY_HEIGHT - 1);

  typedef struct packed {
    logic [1:0]      cmd;
    logic            off;
    logic [15:0]     c_lo;
    logic [15:0]     c_hi;
    logic [15:0]     r_lo;
    logic [15:0]     r_hi;
    logic [DimW-1:0] c_len;
    logic [DimW-1:0] r_len;
    logic [7:0]      pix_hi;
    logic [7:0]      pix_lo;
  } clip_t;

  logic              hash_en_r;
  logic              in_valid_r, in_valid_nxt;
  in_word_t          in_r;
  logic              a_valid_r, a_valid_nxt;
  clip_t             a_r, a_nxt;
  logic              job_valid_r, job_valid_nxt;
  job_t              job_r, job_nxt;
  logic [3:0]        idx_r, idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_r, out_nxt;
  logic [HASH_W-1:0] hash_r, hash_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;

  logic              in_take, a_load, a_drop, b_fire, job_load, job_done, emit;
  logic [15:0]       c_min, c_max, c_clip, r_min, r_max, r_clip, c_diff, r_diff;
  logic [ProdW-1:0]  prod;
  logic [CNT_W-1:0]  cnt_sat, rem_upd;
  logic [HASH_W-1:0] hash_mix, hash_upd;

  // Input register.
  assign in_take      = in_valid && !in_stall;
  assign a_load       = in_valid_r && (!a_valid_r || b_fire);
  assign in_stall     = in_valid_r && !a_load;
  assign in_valid_nxt = in_take ? 1'b1 : (a_load ? 1'b0 : in_valid_r);

  // Clipping stage: sort, clip the far ends, measure; a plot runs to the display edge.
  always_comb begin
    c_min  = (in_r.x_first < in_r.x_second) ? in_r.x_first : in_r.x_second;
    c_max  = (in_r.x_first < in_r.x_second) ? in_r.x_second : in_r.x_first;
    r_min  = (in_r.y_first < in_r.y_second) ? in_r.y_first : in_r.y_second;
    r_max  = (in_r.y_first < in_r.y_second) ? in_r.y_second : in_r.y_first;
    c_clip = (c_max > ColLast) ? ColLast : c_max;
    r_clip = (r_max > RowLast) ? RowLast : r_max;
    c_diff = c_clip - c_min;
    r_diff = r_clip - r_min;

    a_nxt        = '0;
    a_nxt.cmd    = in_r.command;
    a_nxt.pix_hi = {in_r.red[7:3], in_r.green[7:5]};
    a_nxt.pix_lo = {in_r.green[4:2], in_r.blue[7:3]};
    a_nxt.c_len  = c_diff[DimW-1:0] + DimW'(1);
    a_nxt.r_len  = r_diff[DimW-1:0] + DimW'(1);
    if (in_r.command == CMD_PLOT) begin
      a_nxt.c_lo = in_r.x_first;
      a_nxt.c_hi = ColLast;
      a_nxt.r_lo = in_r.y_first;
      a_nxt.r_hi = RowLast;
    end else begin
      a_nxt.off  = (c_min > c_clip) || (r_min > r_clip);
      a_nxt.c_lo = c_min;
      a_nxt.c_hi = c_clip;
      a_nxt.r_lo = r_min;
      a_nxt.r_hi = r_clip;
    end
  end

  assign a_valid_nxt = a_load ? 1'b1 : (b_fire ? 1'b0 : a_valid_r);

  // Counting stage: pixel count, hash update and loading of the byte sequencer.
  assign a_drop   = (a_r.cmd == CMD_NONE) || ((a_r.cmd == CMD_WINDOW) && a_r.off);
  assign emit     = job_valid_r && (!out_valid_r || !out_stall);
  assign job_done = emit && (idx_r == job_r.end_idx);
  assign b_fire   = a_valid_r && (a_drop || !job_valid_r || job_done);
  assign job_load = b_fire && !a_drop;

  assign prod     = ProdW'(a_r.c_len) * ProdW'(a_r.r_len);
  assign cnt_sat  = (ExtW'(prod) > ExtW'(COUNT_MAX)) ? COUNT_MAX : CNT_W'(ExtW'(prod));
  assign hash_mix = hash_r ^ {24'd0, a_r.pix_hi ^ a_r.pix_lo};

  always_comb begin
    rem_upd  = rem_r;
    hash_upd = hash_r;
    case (a_r.cmd)
      CMD_WINDOW: begin
        rem_upd = a_r.off ? '0 : cnt_sat;
      end
      CMD_PIXEL: begin
        rem_upd = (rem_r != '0) ? rem_r - CNT_W'(1) : rem_r;
        if (hash_en_r) begin
          hash_upd = {hash_mix[0], hash_mix[HASH_W-1:1]};
        end
      end
      CMD_PLOT: begin
        if (hash_en_r) begin
          hash_upd = {hash_mix[0], hash_mix[HASH_W-1:1]};
        end
      end
      default: begin
        rem_upd = rem_r;
      end
    endcase
  end

  assign rem_nxt  = b_fire ? rem_upd : rem_r;
  assign hash_nxt = b_fire ? hash_upd : hash_r;

  always_comb begin
    job_nxt             = job_r;
    idx_nxt             = emit ? idx_r + 4'd1 : idx_r;
    job_valid_nxt       = job_done ? 1'b0 : job_valid_r;
    if (job_load) begin
      job_valid_nxt       = 1'b1;
      job_nxt.c_lo        = a_r.c_lo;
      job_nxt.c_hi        = a_r.c_hi;
      job_nxt.r_lo        = a_r.r_lo;
      job_nxt.r_hi        = a_r.r_hi;
      job_nxt.pix_hi      = a_r.pix_hi;
      job_nxt.pix_lo      = a_r.pix_lo;
      job_nxt.pixels_left = rem_upd;
      job_nxt.hash        = hash_upd;
      job_nxt.end_idx     = (a_r.cmd == CMD_WINDOW) ? BYTE_MEM_WRITE : BYTE_PIX_LO;
      idx_nxt             = (a_r.cmd == CMD_PIXEL) ? BYTE_PIX_HI : BYTE_COL_CMD;
    end
  end

  // Byte sequencer feeding the output register.
  always_comb begin
    out_nxt             = out_r;
    out_nxt.is_data     = 1'b1;
    out_nxt.last        = (idx_r == job_r.end_idx);
    out_nxt.pixels_left = job_r.pixels_left;
    out_nxt.image_hash  = job_r.hash;
    unique case (idx_r)
      BYTE_COL_CMD: begin
        out_nxt.bus_byte = OP_COL_SET;
        out_nxt.is_data  = 1'b0;
      end
      BYTE_COL_LO_HI: out_nxt.bus_byte = job_r.c_lo[15:8];
      BYTE_COL_LO_LO: out_nxt.bus_byte = job_r.c_lo[7:0];
      BYTE_COL_HI_HI: out_nxt.bus_byte = job_r.c_hi[15:8];
      BYTE_COL_HI_LO: out_nxt.bus_byte = job_r.c_hi[7:0];
      BYTE_ROW_CMD: begin
        out_nxt.bus_byte = OP_ROW_SET;
        out_nxt.is_data  = 1'b0;
      end
      BYTE_ROW_LO_HI: out_nxt.bus_byte = job_r.r_lo[15:8];
      BYTE_ROW_LO_LO: out_nxt.bus_byte = job_r.r_lo[7:0];
      BYTE_ROW_HI_HI: out_nxt.bus_byte = job_r.r_hi[15:8];
      BYTE_ROW_HI_LO: out_nxt.bus_byte = job_r.r_hi[7:0];
      BYTE_MEM_WRITE: begin
        out_nxt.bus_byte = OP_MEM_WRITE;
        out_nxt.is_data  = 1'b0;
      end
      BYTE_PIX_HI: out_nxt.bus_byte = job_r.pix_hi;
      BYTE_PIX_LO: out_nxt.bus_byte = job_r.pix_lo;
      default:     out_nxt.bus_byte = 8'd0;
    endcase
  end

  assign out_valid_nxt = emit ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
  assign out_valid     = out_valid_r;
  assign out_word      = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_en_r   <= 1'b1;
      in_valid_r  <= 1'b0;
      a_valid_r   <= 1'b0;
      job_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      hash_r      <= '0;
      rem_r       <= '0;
      idx_r       <= BYTE_COL_CMD;
    end else begin
      if (cfg_we) begin
        hash_en_r <= cfg_wdata;
      end
      in_valid_r  <= in_valid_nxt;
      a_valid_r   <= a_valid_nxt;
      job_valid_r <= job_valid_nxt;
      out_valid_r <= out_valid_nxt;
      hash_r      <= hash_nxt;
      rem_r       <= rem_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_r <= in_word;
    end
    if (a_load) begin
      a_r <= a_nxt;
    end
    job_r <= job_nxt;
    if (emit) begin
      out_r <= out_nxt;
    end
  end

  a_cmd_bytes : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.is_data |->
      (out_r.bus_byte == OP_COL_SET) || (out_r.bus_byte == OP_ROW_SET) ||
      (out_r.bus_byte == OP_MEM_WRITE))
    else $error("Command byte with an unknown opcode.");

  a_idx_range : assert property (@(posedge clk) disable iff (!rst_n)
    job_valid_r |-> idx_r <= job_r.end_idx)
    else $error("Byte sequencer ran past the end of its sequence.");

  a_hash_hold : assert property (@(posedge clk) disable iff (!rst_n)
    !b_fire |=> hash_r == $past(hash_r))
    else $error("Hash changed without a request being counted.");

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for lcd_window_pixel_writer: drives drawing request words,
// predicts every bus byte word with its own model and compares them as they leave.
// Depends on lwpw_pkg and the lcd_window_pixel_writer RTL.
`timescale 1ns / 100ps

module testbench;
  import lwpw_pkg::*;

  localparam int DISP_W = 240;
  localparam int DISP_H = 320;
  localparam logic [15:0] COL_LAST = 16'(DISP_W - 1);
  localparam logic [15:0] ROW_LAST = 16'(DISP_H - 1);
  localparam int SETTLE = 12;
  localparam int HOLD_LEN = 400;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PRINT_MAX = 20;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_word;

  lcd_window_pixel_writer #(
    .DISPLAY_WIDTH(DISP_W),
    .DISPLAY_HEIGHT(DISP_H)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word(out_word)
  );

  always #2 clk = ~clk;

  // Model state of the writer.
  logic [31:0] model_hash = '0;
  logic [16:0] model_left = '0;
  logic model_hash_en = 1'b1;

  logic [8:0] seq_q[$];
  out_word_t bus_bytes_due[$];

  int gap_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  int mismatches = 0;
  int bytes_seen = 0;
  int words_sent = 0;
  int cycle_count = 0;

  function automatic void add_byte(input logic is_data, input logic [7:0] b);
    seq_q.push_back({is_data, b});
  endfunction

  function automatic void add_range(input logic [7:0] op, input logic [15:0] lo,
                                    input logic [15:0] hi);
    add_byte(1'b0, op);
    add_byte(1'b1, lo[15:8]);
    add_byte(1'b1, lo[7:0]);
    add_byte(1'b1, hi[15:8]);
    add_byte(1'b1, hi[7:0]);
  endfunction

  function automatic void add_pixel(input logic [7:0] r, input logic [7:0] g,
                                    input logic [7:0] b);
    logic [7:0] hi_b;
    logic [7:0] lo_b;
    hi_b = {r[7:3], g[7:5]};
    lo_b = {g[4:2], b[7:3]};
    add_byte(1'b1, hi_b);
    add_byte(1'b1, lo_b);
    if (model_hash_en) begin
      model_hash = model_hash ^ {24'd0, hi_b ^ lo_b};
      model_hash = {model_hash[0], model_hash[31:1]};
    end
  endfunction

  function automatic void predict_bus_bytes(input in_word_t w);
    logic [15:0] c_min;
    logic [15:0] c_max;
    logic [15:0] r_min;
    logic [15:0] r_max;
    int unsigned area;
    out_word_t o;
    seq_q.delete();
    case (cmd_t'(w.command))
      CMD_WINDOW: begin
        c_min = (w.x_first < w.x_second) ? w.x_first : w.x_second;
        c_max = (w.x_first < w.x_second) ? w.x_second : w.x_first;
        r_min = (w.y_first < w.y_second) ? w.y_first : w.y_second;
        r_max = (w.y_first < w.y_second) ? w.y_second : w.y_first;
        if (c_max > COL_LAST) c_max = COL_LAST;
        if (r_max > ROW_LAST) r_max = ROW_LAST;
        if (c_min > c_max || r_min > r_max) begin
          model_left = '0;
        end else begin
          area = (32'(c_max) - 32'(c_min) + 1) * (32'(r_max) - 32'(r_min) + 1);
          model_left = (area > 32'(COUNT_MAX)) ? COUNT_MAX : area[16:0];
          add_range(OP_COL_SET, c_min, c_max);
          add_range(OP_ROW_SET, r_min, r_max);
          add_byte(1'b0, OP_MEM_WRITE);
        end
      end
      CMD_PIXEL: begin
        add_pixel(w.red, w.green, w.blue);
        if (model_left != 0) model_left = model_left - 1'b1;
      end
      CMD_PLOT: begin
        add_range(OP_COL_SET, w.x_first, COL_LAST);
        add_range(OP_ROW_SET, w.y_first, ROW_LAST);
        add_byte(1'b0, OP_MEM_WRITE);
        add_pixel(w.red, w.green, w.blue);
      end
      default: begin
      end
    endcase
    foreach (seq_q[i]) begin
      o.bus_byte = seq_q[i][7:0];
      o.is_data = seq_q[i][8];
      o.last = (i == seq_q.size() - 1);
      o.pixels_left = model_left;
      o.image_hash = model_hash;
      bus_bytes_due.push_back(o);
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= PRINT_MAX)
      $display("Mismatch in %s at byte word %0d: got %h, want %h", what, bytes_seen, got,
               want);
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (bus_bytes_due.size() == 0) begin
        report_mismatch("unrequested byte word", 32'(out_word.bus_byte), 32'd0);
      end else begin
        want = bus_bytes_due.pop_front();
        if (out_word.bus_byte !== want.bus_byte)
          report_mismatch("bus_byte", 32'(out_word.bus_byte), 32'(want.bus_byte));
        if (out_word.is_data !== want.is_data)
          report_mismatch("is_data", 32'(out_word.is_data), 32'(want.is_data));
        if (out_word.last !== want.last)
          report_mismatch("last", 32'(out_word.last), 32'(want.last));
        if (out_word.pixels_left !== want.pixels_left)
          report_mismatch("pixels_left", 32'(out_word.pixels_left), 32'(want.pixels_left));
        if (out_word.image_hash !== want.image_hash)
          report_mismatch("image_hash", out_word.image_hash, want.image_hash);
      end
      bytes_seen++;
    end
  end

  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d byte words outstanding", CYCLE_LIMIT,
               bus_bytes_due.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_word(input in_word_t w);
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < gap_pct);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    predict_bus_bytes(w);
    words_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (bus_bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_hash_enable(input logic en);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= en;
    @(posedge clk);
    cfg_we <= 1'b0;
    model_hash_en = en;
  endtask

  function automatic in_word_t make_word(input cmd_t c, input logic [15:0] x1,
                                         input logic [15:0] y1, input logic [15:0] x2,
                                         input logic [15:0] y2, input logic [7:0] r,
                                         input logic [7:0] g, input logic [7:0] b);
    in_word_t w;
    w.command = c;
    w.x_first = x1;
    w.y_first = y1;
    w.x_second = x2;
    w.y_second = y2;
    w.red = r;
    w.green = g;
    w.blue = b;
    return w;
  endfunction

  function automatic in_word_t random_word(input cmd_t c);
    return make_word(c, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                     8'($urandom), 8'($urandom), 8'($urandom));
  endfunction

  task automatic test_directed();
    gap_pct = 0;
    stall_pct = 0;
    send_word(make_word(CMD_WINDOW, 0, 0, COL_LAST, ROW_LAST, 8'h00, 8'h00, 8'h00));
    send_word(make_word(CMD_WINDOW, COL_LAST, ROW_LAST, 0, 0, 8'hFF, 8'hFF, 8'hFF));
    send_word(make_word(CMD_WINDOW, 5, 7, 5, 7, 8'h00, 8'h00, 8'h00));
    send_word(make_word(CMD_PIXEL, 0, 0, 0, 0, 8'hFF, 8'hFF, 8'hFF));
    send_word(make_word(CMD_PIXEL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h00, 8'h00,
                        8'h00));
    send_word(make_word(CMD_WINDOW, 100, 200, 16'hFFFF, 16'hFFFF, 8'h12, 8'h34, 8'h56));
    send_word(make_word(CMD_WINDOW, 300, 0, 400, 10, 8'h00, 8'h00, 8'h00));
    send_word(make_word(CMD_WINDOW, 0, 400, 10, 500, 8'h00, 8'h00, 8'h00));
    send_word(make_word(CMD_WINDOW, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF,
                        8'hFF));
    send_word(make_word(CMD_WINDOW, 10, 10, 11, 10, 8'h00, 8'h00, 8'h00));
    send_word(make_word(CMD_PIXEL, 0, 0, 0, 0, 8'hAA, 8'h55, 8'hAA));
    send_word(make_word(CMD_PIXEL, 0, 0, 0, 0, 8'h55, 8'hAA, 8'h55));
    send_word(make_word(CMD_PIXEL, 0, 0, 0, 0, 8'hF8, 8'hFC, 8'hF8));
    send_word(make_word(CMD_PLOT, 0, 0, 0, 0, 8'hFF, 8'h00, 8'hFF));
    send_word(make_word(CMD_PLOT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h00, 8'hFF,
                        8'h00));
    send_word(make_word(CMD_PLOT, COL_LAST, ROW_LAST, 0, 0, 8'h07, 8'h03, 8'h07));
    send_word(make_word(CMD_WINDOW, COL_LAST, ROW_LAST, COL_LAST, ROW_LAST, 8'h00, 8'h00,
                        8'h00));
    send_word(make_word(CMD_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF,
                        8'hFF));
    send_word(make_word(CMD_PIXEL, 0, 0, 0, 0, 8'h80, 8'h80, 8'h80));
    send_word(make_word(CMD_PIXEL, 0, 0, 0, 0, 8'h01, 8'h01, 8'h01));
    drain_results();
  endtask

  task automatic test_hash_disabled();
    write_hash_enable(1'b0);
    send_word(make_word(CMD_WINDOW, 0, 0, 1, 1, 8'h00, 8'h00, 8'h00));
    send_word(make_word(CMD_PIXEL, 0, 0, 0, 0, 8'hC3, 8'h3C, 8'h99));
    send_word(make_word(CMD_PLOT, 20, 30, 0, 0, 8'h66, 8'hE7, 8'h18));
    send_word(make_word(CMD_PIXEL, 0, 0, 0, 0, 8'hFF, 8'h00, 8'hFF));
    write_hash_enable(1'b1);
  endtask

  task automatic test_random_mix(input int n, input int g, input int s, input logic en);
    int done;
    int sel;
    int k;
    in_word_t w;
    logic [15:0] x0;
    logic [15:0] y0;
    write_hash_enable(en);
    gap_pct = g;
    stall_pct = s;
    done = 0;
    while (done < n) begin
      sel = $urandom_range(0, 19);
      if (sel < 12) begin
        w = random_word(CMD_WINDOW);
        x0 = 16'($urandom_range(0, DISP_W + 8));
        y0 = 16'($urandom_range(0, DISP_H + 8));
        w.x_first = x0;
        w.x_second = x0 + 16'($urandom_range(0, 3));
        w.y_first = y0;
        w.y_second = y0 + 16'($urandom_range(0, 2));
        if ($urandom_range(0, 1)) {w.x_first, w.x_second} = {w.x_second, w.x_first};
        if ($urandom_range(0, 1)) {w.y_first, w.y_second} = {w.y_second, w.y_first};
        send_word(w);
        done++;
        k = $urandom_range(0, 10);
        repeat (k) begin
          send_word(random_word(CMD_PIXEL));
          done++;
        end
      end else if (sel < 16) begin
        w = random_word(CMD_PLOT);
        if (sel < 15) begin
          w.x_first = 16'($urandom_range(0, DISP_W - 1));
          w.y_first = 16'($urandom_range(0, DISP_H - 1));
        end
        send_word(w);
        done++;
      end else if (sel < 18) begin
        send_word(random_word(CMD_WINDOW));
        done++;
      end else if (sel < 19) begin
        w = random_word(CMD_WINDOW);
        w.x_first = 16'($urandom_range(0, DISP_W - 1));
        w.x_second = 16'($urandom_range(0, DISP_W - 1));
        w.y_first = 16'($urandom_range(0, DISP_H - 1));
        w.y_second = 16'($urandom_range(0, DISP_H - 1));
        send_word(w);
        done++;
      end else begin
        send_word(random_word(CMD_NONE));
      end
    end
    drain_results();
  endtask

  task automatic test_output_hold();
    gap_pct = 0;
    stall_pct = 0;
    hold_req = hold_req + 1;
    send_word(make_word(CMD_WINDOW, 0, 0, 5, 5, 8'h00, 8'h00, 8'h00));
    repeat (40) send_word(random_word(CMD_PIXEL));
    drain_results();
    stall_pct = 32;
    repeat (5) send_word(random_word(CMD_PLOT));
    drain_results();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_hash_disabled();
    test_random_mix(70, 0, 0, 1'b1);
    test_random_mix(70, 59, 0, 1'b0);
    test_random_mix(70, 0, 59, 1'b1);
    test_random_mix(70, 32, 32, 1'b1);
    test_output_hold();
    drain_results();
    $display("Ran %0d request words giving %0d bus byte words: windows, clipping, pixels,",
             words_sent, bytes_seen);
    $display("plots and unused codes, hash on and off, varied idling and a long output hold.");
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches found", mismatches);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/lwpw_pkg.sv
hw/rtl/lcd_window_pixel_writer.sv
tb/testbench.sv
